[hdl/jbe_pkg.sv]
// Shared types and constants for the joystick and button event encoder.
`timescale 1ns / 1ps

package jbe_pkg;

  localparam int AXIS_W  = 14;
  localparam int INDEX_W = 3;
  localparam int EVENT_W = 3;
  localparam int IN_W    = 32;
  localparam int OUT_W   = 8;

  typedef logic [AXIS_W-1:0]  axis_t;
  typedef logic [INDEX_W-1:0] reg_index_t;

  // register map
  localparam reg_index_t REG_PRESS_HIGH   = 3'd0;
  localparam reg_index_t REG_PRESS_LOW    = 3'd1;
  localparam reg_index_t REG_HORIZ_CTR_LO = 3'd2;
  localparam reg_index_t REG_HORIZ_CTR_HI = 3'd3;
  localparam reg_index_t REG_VERT_CTR_LO  = 3'd4;
  localparam reg_index_t REG_VERT_CTR_HI  = 3'd5;

  localparam axis_t PRESS_HIGH_RST   = 14'd15000;
  localparam axis_t PRESS_LOW_RST    = 14'd50;
  localparam axis_t HORIZ_CTR_LO_RST = 14'd6500;
  localparam axis_t HORIZ_CTR_HI_RST = 14'd8000;
  localparam axis_t VERT_CTR_LO_RST  = 14'd7500;
  localparam axis_t VERT_CTR_HI_RST  = 14'd9000;

  typedef struct packed {
    axis_t press_high_level;
    axis_t press_low_level;
    axis_t horiz_center_low;
    axis_t horiz_center_high;
    axis_t vert_center_low;
    axis_t vert_center_high;
  } jbe_cfg_t;

  typedef enum logic [1:0] {
    STICK_START = 2'd0,
    STICK_IDLE  = 2'd1,
    STICK_HORIZ = 2'd2,
    STICK_VERT  = 2'd3
  } stick_mode_t;

  typedef enum logic [2:0] {
    KEY_START = 3'd0,
    KEY_IDLE  = 3'd1,
    KEY_SPACE = 3'd2,
    KEY_X     = 3'd3,
    KEY_Z     = 3'd4
  } key_mode_t;

  typedef enum logic [EVENT_W-1:0] {
    SE_NONE    = 3'd0,
    SE_RIGHT   = 3'd1,
    SE_LEFT    = 3'd2,
    SE_UP      = 3'd3,
    SE_DOWN    = 3'd4,
    SE_H_REL   = 3'd5,
    SE_V_REL   = 3'd6
  } stick_event_t;

  typedef enum logic [EVENT_W-1:0] {
    KE_NONE     = 3'd0,
    KE_Z        = 3'd1,
    KE_SPACE    = 3'd2,
    KE_X        = 3'd3,
    KE_Z_UP     = 3'd4,
    KE_SPACE_UP = 3'd5,
    KE_X_UP     = 3'd6
  } key_event_t;

endpackage

[hdl/jbe_core.sv]
// Stick and key state machines: event decode and mode registers.
`timescale 1ns / 1ps

module jbe_core import jbe_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         advance,
  input  jbe_cfg_t     cfg,
  input  axis_t        axis_horiz,
  input  axis_t        axis_vert,
  input  logic         button_z_down,
  input  logic         button_space_down,
  input  logic         button_x_down,
  output stick_event_t stick_event,
  output key_event_t   key_event
);

  stick_mode_t stick_mode, stick_mode_next;
  key_mode_t   key_mode, key_mode_next;

  logic h_high, h_low, v_high, v_low, h_centre, v_centre;

  assign h_high   = axis_horiz > cfg.press_high_level;
  assign h_low    = axis_horiz < cfg.press_low_level;
  assign v_high   = axis_vert > cfg.press_high_level;
  assign v_low    = axis_vert < cfg.press_low_level;
  assign h_centre = (axis_horiz > cfg.horiz_center_low) &&
                    (axis_horiz < cfg.horiz_center_high);
  assign v_centre = (axis_vert > cfg.vert_center_low) &&
                    (axis_vert < cfg.vert_center_high);

  always_ff @(posedge clk) begin
    if (rst) begin
      stick_mode <= STICK_START;
      key_mode   <= KEY_START;
    end else if (advance) begin
      stick_mode <= stick_mode_next;
      key_mode   <= key_mode_next;
    end
  end

  // stick next state
  always_comb begin
    stick_mode_next = stick_mode;
    case (stick_mode)
      STICK_START: stick_mode_next = STICK_IDLE;
      STICK_IDLE: begin
        if (h_high || h_low) begin
          stick_mode_next = STICK_HORIZ;
        end else if (v_high || v_low) begin
          stick_mode_next = STICK_VERT;
        end
      end
      STICK_HORIZ: if (h_centre) stick_mode_next = STICK_IDLE;
      STICK_VERT:  if (v_centre) stick_mode_next = STICK_IDLE;
      default:     stick_mode_next = STICK_START;
    endcase
  end

  // stick event
  always_comb begin
    stick_event = SE_NONE;
    case (stick_mode)
      STICK_IDLE: begin
        if (h_high) begin
          stick_event = SE_RIGHT;
        end else if (h_low) begin
          stick_event = SE_LEFT;
        end else if (v_high) begin
          stick_event = SE_UP;
        end else if (v_low) begin
          stick_event = SE_DOWN;
        end
      end
      STICK_HORIZ: if (h_centre) stick_event = SE_H_REL;
      STICK_VERT:  if (v_centre) stick_event = SE_V_REL;
      default:     stick_event = SE_NONE;
    endcase
  end

  // key next state; unused codes fall back to start
  always_comb begin
    key_mode_next = key_mode;
    case (key_mode)
      KEY_START: key_mode_next = KEY_IDLE;
      KEY_IDLE: begin
        if (button_z_down) begin
          key_mode_next = KEY_Z;
        end else if (button_space_down) begin
          key_mode_next = KEY_SPACE;
        end else if (button_x_down) begin
          key_mode_next = KEY_X;
        end
      end
      KEY_Z:     if (!button_z_down) key_mode_next = KEY_IDLE;
      KEY_SPACE: if (!button_space_down) key_mode_next = KEY_IDLE;
      KEY_X:     if (!button_x_down) key_mode_next = KEY_IDLE;
      default:   key_mode_next = KEY_START;
    endcase
  end

  // key event
  always_comb begin
    key_event = KE_NONE;
    case (key_mode)
      KEY_IDLE: begin
        if (button_z_down) begin
          key_event = KE_Z;
        end else if (button_space_down) begin
          key_event = KE_SPACE;
        end else if (button_x_down) begin
          key_event = KE_X;
        end
      end
      KEY_Z:     if (!button_z_down) key_event = KE_Z_UP;
      KEY_SPACE: if (!button_space_down) key_event = KE_SPACE_UP;
      KEY_X:     if (!button_x_down) key_event = KE_X_UP;
      default:   key_event = KE_NONE;
    endcase
  end

endmodule

[hdl/joystick_button_event_encoder.sv]
// Joystick and button event encoder, top level.
//
//   channel  dir  handshake                     payload
//   s_axis   in   s_axis_tvalid/s_axis_tready   s_axis_tdata[31:0] one sample tick
//   m_axis   out  m_axis_tvalid/m_axis_tready   m_axis_tdata[7:0]  stick and key event
//   cfg      in   cfg_valid/cfg_ready           cfg_index[2:0], cfg_data[13:0]
//
// One beat in gives one beat out; a beat can enter every cycle unless m_axis stalls.
// Path: input register, then decode and mode update into the output register.
// rst clears the machines to their start state and the thresholds to defaults.
// A stall on m_axis holds the output register; an empty input register takes one
// more beat, a full one drops s_axis_tready in the same cycle. cfg_ready is always high.
`timescale 1ns / 1ps

module joystick_button_event_encoder import jbe_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // [13:0] axis_horiz, [27:14] axis_vert, [28] button_z_down,
  // [29] button_space_down, [30] button_x_down, [31] unused
  input  logic [IN_W-1:0]    s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [2:0] stick_event, [5:3] key_event, [7:6] zero
  output logic [OUT_W-1:0]   m_axis_tdata,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  reg_index_t         cfg_index,
  input  axis_t              cfg_data
);

  jbe_cfg_t cfg;

  logic              in_valid;
  logic [IN_W-2:0]   in_data;
  logic              fire;
  logic              out_free;
  stick_event_t      stick_event;
  key_event_t        key_event;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_high_level  <= PRESS_HIGH_RST;
      cfg.press_low_level   <= PRESS_LOW_RST;
      cfg.horiz_center_low  <= HORIZ_CTR_LO_RST;
      cfg.horiz_center_high <= HORIZ_CTR_HI_RST;
      cfg.vert_center_low   <= VERT_CTR_LO_RST;
      cfg.vert_center_high  <= VERT_CTR_HI_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PRESS_HIGH:   cfg.press_high_level  <= cfg_data;
        REG_PRESS_LOW:    cfg.press_low_level   <= cfg_data;
        REG_HORIZ_CTR_LO: cfg.horiz_center_low  <= cfg_data;
        REG_HORIZ_CTR_HI: cfg.horiz_center_high <= cfg_data;
        REG_VERT_CTR_LO:  cfg.vert_center_low   <= cfg_data;
        REG_VERT_CTR_HI:  cfg.vert_center_high  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign fire          = in_valid && out_free;
  assign s_axis_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data <= s_axis_tdata[IN_W-2:0];
    end
  end

  jbe_core u_core (
    .clk               (clk),
    .rst               (rst),
    .advance           (fire),
    .cfg               (cfg),
    .axis_horiz        (in_data[AXIS_W-1:0]),
    .axis_vert         (in_data[2*AXIS_W-1:AXIS_W]),
    .button_z_down     (in_data[2*AXIS_W]),
    .button_space_down (in_data[2*AXIS_W+1]),
    .button_x_down     (in_data[2*AXIS_W+2]),
    .stick_event       (stick_event),
    .key_event         (key_event)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_axis_tdata <= {2'b00, key_event, stick_event};
    end
  end

endmodule
